>>> rtl/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants for the column symbol apportion block.
// ----------------------------------------------------------------------------
`default_nettype none

package csa_pkg;

   localparam int NUM_CODES = 32;
   localparam int IDX_W     = $clog2(NUM_CODES);
   localparam int SYM_W     = 5;
   localparam int SUM_W     = 23;
   localparam int FRAC_W    = 16;
   localparam int WHOLE_W   = SUM_W - FRAC_W;
   localparam int CNT_W     = WHOLE_W + 1;
   localparam int TOT_W     = 12;
   localparam int OCNT_W    = 7;
   localparam logic [OCNT_W-1:0] EMIT_MAX = OCNT_W'(64);

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic [SUM_W-1:0] weight;
      logic             column_end;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] out_symbol;
      logic             run_end;
   } rsp_type;

   typedef struct packed {
      logic col_start;
      logic scan_start;
      logic used_clr;
      logic accum;
      logic whole_step;
      logic rank_step;
      logic rank_take;
      logic pick_step;
      logic pick_take;
      logic emit_step;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic found;
      logic below_target;
      logic none_to_emit;
      logic out_free;
      logic emit_last;
      logic rep_one;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/csa_dpath.sv
// ----------------------------------------------------------------------------
// csa_dpath
// Histogram, count table, scan comparator, output register and out_count.
// ----------------------------------------------------------------------------
`default_nettype none

module csa_dpath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire csa_pkg::req_type   req_word,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   output csa_pkg::rsp_type        rsp_word,
   input  wire logic               csr_write,
   input  wire logic [csa_pkg::OCNT_W-1:0] csr_data,
   input  wire csa_pkg::cmd_type   cmd,
   output csa_pkg::status_type     status
);

   logic [csa_pkg::SUM_W-1:0]  sums_ff [csa_pkg::NUM_CODES];
   logic [csa_pkg::CNT_W-1:0]  cnt_ff  [csa_pkg::NUM_CODES];
   logic [csa_pkg::NUM_CODES-1:0] used_ff;
   logic [csa_pkg::IDX_W-1:0]  idx_ff;
   logic [csa_pkg::IDX_W-1:0]  best_ff;
   logic [csa_pkg::FRAC_W-1:0] bestv_ff;
   logic                       found_ff;
   logic [csa_pkg::TOT_W-1:0]  total_ff;
   logic [csa_pkg::OCNT_W-1:0] emitted_ff;
   logic [csa_pkg::CNT_W-1:0]  rep_ff;
   logic [csa_pkg::OCNT_W-1:0] ocount_ff;
   logic                       rsp_valid_ff;
   csa_pkg::rsp_type           rsp_word_ff;

   logic [csa_pkg::IDX_W-1:0]   rd_addr;
   logic [csa_pkg::SUM_W-1:0]   sum_rd;
   logic [csa_pkg::SUM_W:0]     sum_add;
   logic [csa_pkg::SUM_W-1:0]   sum_sat;
   logic [csa_pkg::FRAC_W-1:0]  frac;
   logic [csa_pkg::WHOLE_W-1:0] whole;
   logic [csa_pkg::IDX_W-1:0]   cnt_addr;
   logic [csa_pkg::CNT_W-1:0]   cnt_rd;
   logic [csa_pkg::OCNT_W-1:0]  target;
   logic [csa_pkg::OCNT_W-1:0]  emit_n;
   logic [csa_pkg::OCNT_W-1:0]  emitted_inc;
   logic                        below;
   logic                        rank_hit;
   logic                        pick_hit;
   logic                        in_range;

   always_comb begin
      in_range = {1'b0, req_word.symbol} < (csa_pkg::SYM_W + 1)'(csa_pkg::NUM_CODES);
      rd_addr  = cmd.accum ? req_word.symbol[csa_pkg::IDX_W-1:0] : idx_ff;
      sum_rd   = sums_ff[rd_addr];
      sum_add  = {1'b0, sum_rd} + {1'b0, req_word.weight};
      sum_sat  = sum_add[csa_pkg::SUM_W] ? '1 : sum_add[csa_pkg::SUM_W-1:0];
      frac     = sum_rd[csa_pkg::FRAC_W-1:0];
      whole    = sum_rd[csa_pkg::SUM_W-1:csa_pkg::FRAC_W];
      cnt_addr = cmd.rank_take ? best_ff : idx_ff;
      cnt_rd   = cnt_ff[cnt_addr];
      target   = (ocount_ff > csa_pkg::EMIT_MAX) ? csa_pkg::EMIT_MAX : ocount_ff;
      below    = total_ff < csa_pkg::TOT_W'(target);
      emit_n   = below ? total_ff[csa_pkg::OCNT_W-1:0] : target;
      emitted_inc = emitted_ff + csa_pkg::OCNT_W'(1);
      rank_hit = !used_ff[idx_ff] && (!found_ff || frac > bestv_ff);
      pick_hit = !used_ff[idx_ff] && (csa_pkg::FRAC_W'(cnt_rd) > bestv_ff);

      status.idx_last     = idx_ff == csa_pkg::IDX_W'(csa_pkg::NUM_CODES - 1);
      status.found        = found_ff;
      status.below_target = below;
      status.none_to_emit = emit_n == '0;
      status.out_free     = !rsp_valid_ff || !rsp_stall;
      status.emit_last    = emitted_inc == emit_n;
      status.rep_one      = rep_ff == csa_pkg::CNT_W'(1);
   end

   // tables
   always_ff @(posedge clock) begin
      if (cmd.accum && in_range) begin
         sums_ff[rd_addr] <= sum_sat;
      end
      if (cmd.clear_step) begin
         sums_ff[idx_ff] <= '0;
      end
      if (cmd.whole_step) begin
         cnt_ff[idx_ff] <= {1'b0, whole};
      end
      if (cmd.rank_take && found_ff) begin
         cnt_ff[best_ff] <= cnt_rd + csa_pkg::CNT_W'(1);
      end
      if (cmd.pick_take) begin
         rep_ff <= bestv_ff[csa_pkg::CNT_W-1:0];
      end else if (cmd.emit_step) begin
         rep_ff <= rep_ff - csa_pkg::CNT_W'(1);
      end
      if (cmd.emit_step) begin
         rsp_word_ff.out_symbol <= csa_pkg::SYM_W'(best_ff);
         rsp_word_ff.run_end    <= status.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         best_ff      <= '0;
         bestv_ff     <= '0;
         found_ff     <= 1'b0;
         used_ff      <= '0;
         total_ff     <= '0;
         emitted_ff   <= '0;
         ocount_ff    <= csa_pkg::OCNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            idx_ff <= '0;
         end else if (cmd.whole_step || cmd.rank_step || cmd.pick_step || cmd.clear_step) begin
            idx_ff <= idx_ff + csa_pkg::IDX_W'(1);
         end

         if (cmd.scan_start) begin
            found_ff <= 1'b0;
            bestv_ff <= '0;
         end else if ((cmd.rank_step && rank_hit) || (cmd.pick_step && pick_hit)) begin
            found_ff <= 1'b1;
            best_ff  <= idx_ff;
            bestv_ff <= cmd.rank_step ? frac : csa_pkg::FRAC_W'(cnt_rd);
         end

         if (cmd.used_clr) begin
            used_ff <= '0;
         end else if ((cmd.rank_take && found_ff) || cmd.pick_take) begin
            used_ff[best_ff] <= 1'b1;
         end

         if (cmd.col_start) begin
            total_ff <= '0;
         end else if (cmd.whole_step) begin
            total_ff <= total_ff + csa_pkg::TOT_W'(whole);
         end else if (cmd.rank_take && found_ff) begin
            total_ff <= total_ff + csa_pkg::TOT_W'(1);
         end

         if (cmd.col_start) begin
            emitted_ff <= '0;
         end else if (cmd.emit_step) begin
            emitted_ff <= emitted_inc;
         end

         if (csr_write) begin
            ocount_ff <= csr_data;
         end

         if (cmd.emit_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

>>> rtl/csa_cntl.sv
// ----------------------------------------------------------------------------
// csa_cntl
// Sequencer: accumulate, whole parts, remainder ranking, emission, clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module csa_cntl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last,
   output logic                     req_stall,
   input  wire csa_pkg::status_type status,
   output csa_pkg::cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WHOLE, S_RANK_CHECK, S_RANK_SCAN, S_RANK_TAKE,
      S_PICK_START, S_PICK_SCAN, S_PICK_TAKE, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_last) begin
                  cmd.col_start  = 1'b1;
                  cmd.scan_start = 1'b1;
                  cmd.used_clr   = 1'b1;
                  state_in       = S_WHOLE;
               end
            end
         end
         S_WHOLE: begin
            cmd.whole_step = 1'b1;
            if (status.idx_last) state_in = S_RANK_CHECK;
         end
         S_RANK_CHECK: begin
            if (status.below_target) begin
               cmd.scan_start = 1'b1;
               state_in       = S_RANK_SCAN;
            end else begin
               state_in = S_PICK_START;
            end
         end
         S_RANK_SCAN: begin
            cmd.rank_step = 1'b1;
            if (status.idx_last) state_in = S_RANK_TAKE;
         end
         S_RANK_TAKE: begin
            cmd.rank_take = 1'b1;
            state_in = status.found ? S_RANK_CHECK : S_PICK_START;
         end
         S_PICK_START: begin
            cmd.used_clr   = 1'b1;
            cmd.scan_start = 1'b1;
            state_in = status.none_to_emit ? S_CLEAR : S_PICK_SCAN;
         end
         S_PICK_SCAN: begin
            cmd.pick_step = 1'b1;
            if (status.idx_last) state_in = S_PICK_TAKE;
         end
         S_PICK_TAKE: begin
            cmd.pick_take = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_step = 1'b1;
               if (status.emit_last) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_CLEAR;
               end else if (status.rep_one) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_PICK_SCAN;
               end
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= state_in != S_IDLE;
      end
   end

   assign req_stall = stall_ff;

endmodule

`default_nettype wire

>>> rtl/column_symbol_apportion.sv
// ----------------------------------------------------------------------------
// column_symbol_apportion
// Largest-remainder apportionment of one column of weighted symbols.
// ----------------------------------------------------------------------------
// req channel: one word per column member (symbol, 7.16 weight, column_end).
// A member word is taken and added, saturating, to its symbol's
// sum. The word with column_end set closes the column; req_stall then stays
// high until the column has been emitted and the histogram cleared.
// After the closing word: a whole-part pass over the sum table, then per extra
// unit handed out a full remainder scan of the sum table, then per emitted
// symbol group a count scan followed by its emitted words, then a clearing
// pass. Scans go one table entry per cycle.
// rsp channel: out_count words (fewer if the symbols run out), grouped by
// descending count, run_end on the last one. The output register holds a
// word while rsp_stall is high; the sequencer waits for it to free up.
// csr: csr_write loads out_count (values above 64 act as 64, zero emits
// nothing). Reset sets out_count to 1 and runs the clearing pass, during
// which req_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module column_symbol_apportion (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire csa_pkg::req_type           req_word,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output csa_pkg::rsp_type                rsp_word,
   input  wire logic                       csr_write,
   input  wire logic [csa_pkg::OCNT_W-1:0] csr_data
);

   csa_pkg::cmd_type    cmd;
   csa_pkg::status_type status;

   csa_cntl u_cntl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_word.column_end),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   csa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

>>> rtl/csa_checker.sv
// ----------------------------------------------------------------------------
// csa_checker
// Port-level checks for column_symbol_apportion, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csa_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire csa_pkg::req_type           req_word,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire csa_pkg::rsp_type           rsp_word
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("req not stalled after reset");

   // closing word starts the apportion phase
   a_close_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.column_end |=> req_stall)
      else $error("req taken right after column end");

endmodule

bind column_symbol_apportion csa_checker u_csa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire
